// ----- rtl/tls_pkg.sv -----
// Shared constants, types and helpers for the transpose list search unit.
package tls_pkg;

	// List memory geometry
	localparam int LIST_DEPTH = 1024;
	localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// Field widths fixed by the interface
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 10;
	localparam int POS_W      = 10;
	localparam int LEN_W      = 11;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// Operation codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP,
		ST_RESULT
	} state_t;

	// Request to the list memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Finished search result
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

	// Map a list address onto the reported position field
	function automatic logic [POS_W-1:0] to_pos(input logic [ADDR_W-1:0] addr);
		logic [31:0] wide;
		wide = 32'(addr);
		return wide[POS_W-1:0];
	endfunction

endpackage

// ----- rtl/tls_store.sv -----
// List memory: one write port and one registered read port.
module tls_store (
	input  logic                           clk,
	input  tls_pkg::mem_req_t              req,
	output logic [tls_pkg::DATA_W-1:0]     rdata
);

	logic [tls_pkg::DATA_W-1:0] mem_q [tls_pkg::LIST_DEPTH];
	logic [tls_pkg::DATA_W-1:0] rdata_q;

	// Write one entry when requested
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read one entry every cycle, data registered
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tls_ctrl.sv -----
// Search sequencer: walks the list with one comparator, swaps a hit past index 0.
module tls_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tls_pkg::LEN_W-1:0]     list_length,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [tls_pkg::IDX_W-1:0]     entry_index,
	input  logic [tls_pkg::DATA_W-1:0]    entry_value,
	output tls_pkg::mem_req_t             mem_req,
	input  logic [tls_pkg::DATA_W-1:0]    rdata,
	output logic                          res_valid,
	input  logic                          res_take,
	output tls_pkg::result_t              res
);

	tls_pkg::state_t                state_q, state_d;
	logic [tls_pkg::DATA_W-1:0]     key_q, key_d;
	logic [tls_pkg::DATA_W-1:0]     prev_q, prev_d;
	logic [tls_pkg::ADDR_W-1:0]     cmp_q, cmp_d;
	logic                           found_q, found_d;
	logic [tls_pkg::POS_W-1:0]      pos_q, pos_d;

	logic [tls_pkg::CNT_W-1:0]      eff_len;
	logic                           load_ok;
	logic                           last_idx;
	logic                           hit;

	// Clamp the configured length to the memory depth
	always_comb begin
		if (32'(list_length) > 32'(tls_pkg::LIST_DEPTH)) begin
			eff_len = tls_pkg::CNT_W'(tls_pkg::LIST_DEPTH);
		end else begin
			eff_len = tls_pkg::CNT_W'(list_length);
		end
	end

	assign load_ok  = 32'(entry_index) < 32'(tls_pkg::LIST_DEPTH);
	assign last_idx = (tls_pkg::CNT_W'(cmp_q) + tls_pkg::CNT_W'(1)) == eff_len;
	assign hit      = (rdata == key_q);

	// State and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		prev_q  <= prev_d;
		cmp_q   <= cmp_d;
		found_q <= found_d;
		pos_q   <= pos_d;
	end

	// Next state, memory requests and handshakes
	always_comb begin
		state_d       = state_q;
		key_d         = key_q;
		prev_d        = prev_q;
		cmp_d         = cmp_q;
		found_d       = found_q;
		pos_d         = pos_q;
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = tls_pkg::ADDR_W'(entry_index);
		mem_req.wdata = entry_value;
		mem_req.raddr = '0;

		unique case (state_q)
			tls_pkg::ST_IDLE: begin
				// Keep entry zero on the read port so a scan starts at once
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == tls_pkg::OP_LOAD) begin
						mem_req.we = load_ok;
					end else begin
						key_d = entry_value;
						cmp_d = '0;
						if (eff_len == '0) begin
							found_d = 1'b0;
							pos_d   = '0;
							state_d = tls_pkg::ST_RESULT;
						end else begin
							state_d = tls_pkg::ST_SCAN;
						end
					end
				end
			end
			tls_pkg::ST_SCAN: begin
				// Compare entry cmp_q, prefetch the next one
				mem_req.raddr = cmp_q + tls_pkg::ADDR_W'(1);
				if (hit) begin
					found_d = 1'b1;
					if (cmp_q == '0) begin
						pos_d   = '0;
						state_d = tls_pkg::ST_RESULT;
					end else begin
						// First half of the swap: key moves up one place
						mem_req.we    = 1'b1;
						mem_req.waddr = cmp_q - tls_pkg::ADDR_W'(1);
						mem_req.wdata = key_q;
						pos_d         = tls_pkg::to_pos(cmp_q - tls_pkg::ADDR_W'(1));
						state_d       = tls_pkg::ST_SWAP;
					end
				end else if (last_idx) begin
					found_d = 1'b0;
					pos_d   = '0;
					state_d = tls_pkg::ST_RESULT;
				end else begin
					cmp_d  = cmp_q + tls_pkg::ADDR_W'(1);
					prev_d = rdata;
				end
			end
			tls_pkg::ST_SWAP: begin
				// Second half of the swap: old neighbor drops into the hit slot
				mem_req.we    = 1'b1;
				mem_req.waddr = cmp_q;
				mem_req.wdata = prev_q;
				state_d       = tls_pkg::ST_RESULT;
			end
			tls_pkg::ST_RESULT: begin
				// Hold until the output register is free
				res_valid = 1'b1;
				if (res_take) begin
					state_d = tls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tls_pkg::ST_IDLE;
			end
		endcase
	end

	assign res.found    = found_q;
	assign res.position = pos_q;

endmodule

// ----- rtl/transpose_list_search_unit.sv -----
// Top level of the transpose list search unit: config register, sequencer, memory, output item.
//
// Self-organizing list with the transpose heuristic. A load item writes one entry and
// gives no result. A search item scans entries from index 0, one per cycle through
// the single read port of the list memory, up to list_length clamped to the memory
// depth, and keeps the block busy until it ends. A finished search also waits while
// the output register still holds an unaccepted result. A hit past index 0 swaps the
// entry with its predecessor and reports the new position. The result sits in an
// output register, so the next item is accepted while it waits. The list memory is
// not cleared at reset; search only entries that were loaded. Write list_length only
// while the block is idle.
module transpose_list_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tls_pkg::LEN_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [tls_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [tls_pkg::DATA_W-1:0] entry_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [tls_pkg::POS_W-1:0]         position
);

	logic [tls_pkg::LEN_W-1:0]  list_length_q;
	tls_pkg::mem_req_t          mem_req;
	logic [tls_pkg::DATA_W-1:0] rdata;
	logic                       res_valid;
	logic                       res_take;
	tls_pkg::result_t           res;
	logic                       out_valid_q;
	tls_pkg::result_t           out_q;

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= tls_pkg::LEN_RESET;
		end else if (cfg_wr_en) begin
			list_length_q <= cfg_wr_data;
		end
	end

	tls_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.list_length (list_length_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.mem_req     (mem_req),
		.rdata       (rdata),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	tls_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Output register: load when empty or being drained
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_q.found;
	assign position  = out_q.position;

	// A search item occupies the sequencer
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == tls_pkg::OP_SEARCH) |=> !in_ready)
		else $error("ready after search item");

	// A load item leaves the sequencer free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == tls_pkg::OP_LOAD) |=> in_ready)
		else $error("not ready after load item");

	// A result item only comes from a finished search
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res_valid))
		else $error("result item without a finished search");

	// A miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> (res.position == '0))
		else $error("nonzero position on a miss");

endmodule

// ----- dv/transpose_list_search_unit_test.sv -----
// Self-checking testbench for the transpose list search unit: directed, long-scan and random tests.
module transpose_list_search_unit_test;

	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_REPORTS     = 10;
	localparam int LONG_FILL       = 256;
	localparam int PHASE_ITEMS     = 68;

	logic                              clk         = 1'b0;
	logic                              arst_n      = 1'b0;
	logic                              cfg_wr_en   = 1'b0;
	logic [tls_pkg::LEN_W-1:0]         cfg_wr_data = '0;
	logic                              in_valid    = 1'b0;
	logic                              in_ready;
	logic                              opcode      = tls_pkg::OP_LOAD;
	logic [tls_pkg::IDX_W-1:0]         entry_index = '0;
	logic signed [tls_pkg::DATA_W-1:0] entry_value = '0;
	logic                              out_valid;
	logic                              out_ready   = 1'b0;
	logic                              found;
	logic [tls_pkg::POS_W-1:0]         position;

	// Mirror of the list contents, which entries were loaded, and the length register
	logic [tls_pkg::DATA_W-1:0] list_mirror [tls_pkg::LIST_DEPTH];
	bit                         loaded_mask [tls_pkg::LIST_DEPTH];
	int unsigned                list_len_mirror = tls_pkg::LEN_RESET;

	// Search outcomes still owed by the block, oldest first
	tls_pkg::result_t search_results_due [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_seq       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	transpose_list_search_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.position   (position)
	);

	// Free-running clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Search length after clamping to the list depth
	function automatic int unsigned effective_length();
		return (list_len_mirror > tls_pkg::LIST_DEPTH) ? tls_pkg::LIST_DEPTH : list_len_mirror;
	endfunction

	// Count loaded entries contiguous from index zero
	function automatic int unsigned loaded_prefix();
		int unsigned n;
		n = 0;
		while (n < tls_pkg::LIST_DEPTH && loaded_mask[n])
			n++;
		return n;
	endfunction

	// Scan for the key, move the first hit one step toward the front
	function automatic tls_pkg::result_t transpose_lookup(
			input logic [tls_pkg::DATA_W-1:0] key);
		tls_pkg::result_t           res;
		int unsigned                len;
		logic [tls_pkg::DATA_W-1:0] held;
		res = '0;
		len = effective_length();
		for (int unsigned k = 0; k < len; k++) begin
			if (list_mirror[k] == key) begin
				res.found = 1'b1;
				if (k > 0) begin
					held             = list_mirror[k-1];
					list_mirror[k-1] = list_mirror[k];
					list_mirror[k]   = held;
					res.position     = tls_pkg::POS_W'(k - 1);
				end
				return res;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Offer one item, hold it until accepted, then update the mirror
	task automatic send_item(input logic op, input logic [tls_pkg::IDX_W-1:0] idx,
			input logic [tls_pkg::DATA_W-1:0] val);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (!in_ready);
		if (op == tls_pkg::OP_LOAD) begin
			list_mirror[idx] = val;
			loaded_mask[idx] = 1'b1;
		end else begin
			search_results_due.push_back(transpose_lookup(val));
		end
	endtask

	task automatic send_load(input int unsigned idx, input logic [tls_pkg::DATA_W-1:0] val);
		send_item(tls_pkg::OP_LOAD, tls_pkg::IDX_W'(idx), val);
	endtask

	task automatic send_search(input logic [tls_pkg::DATA_W-1:0] key);
		send_item(tls_pkg::OP_SEARCH,
			tls_pkg::IDX_W'($urandom_range(tls_pkg::LIST_DEPTH - 1)), key);
	endtask

	// Drop valid, wait for every owed result, then let a trailing load finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (search_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [tls_pkg::LEN_W-1:0] len);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en       <= 1'b0;
		list_len_mirror = len;
	endtask

	// One random item: mostly loads near the front and hits, some misses and noise
	task automatic random_item(input int unsigned window);
		int unsigned                len;
		int unsigned                prefix;
		int unsigned                reach;
		int unsigned                k;
		int unsigned                pick;
		logic [tls_pkg::DATA_W-1:0] val;
		len    = effective_length();
		prefix = loaded_prefix();
		reach  = (len < window) ? len : window;
		pick   = $urandom_range(99);
		if (pick < 40 || (len > 0 && prefix == 0)) begin
			if (reach == 0 || $urandom_range(9) == 0)
				k = $urandom_range(tls_pkg::LIST_DEPTH - 1);
			else
				k = $urandom_range(reach - 1);
			val = $urandom;
			if (prefix > 0 && $urandom_range(9) == 0) begin
				val = list_mirror[$urandom_range(prefix - 1)];
			end else if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = '0;
					default: val = '1;
				endcase
			end
			send_load(k, val);
		end else if ((pick < 80 || prefix < len) && prefix > 0 && reach > 0) begin
			k = $urandom_range(((reach < prefix) ? reach : prefix) - 1);
			send_search(list_mirror[k]);
		end else begin
			send_search($urandom);
		end
	endtask

	// Default length after reset: hits within a small loaded front
	task automatic test_reset_length();
		for (int unsigned i = 0; i < 4; i++)
			send_load(i, $urandom);
		send_search(list_mirror[3]);
		send_search(list_mirror[2]);
		send_search(list_mirror[1]);
		send_search(list_mirror[0]);
	endtask

	// Value extremes, hits at both ends, duplicates, misses, length one and zero
	task automatic test_extremes();
		write_length(tls_pkg::LEN_W'(8));
		send_load(0, 32'h8000_0000);
		send_load(1, 32'h7FFF_FFFF);
		send_load(2, 32'h0000_0000);
		send_load(3, 32'hFFFF_FFFF);
		send_load(4, 32'hAAAA_AAAA);
		send_load(5, 32'h5555_5555);
		send_load(6, 32'h8000_0000);
		send_load(7, 32'h0000_0001);
		send_load(tls_pkg::LIST_DEPTH - 1, 32'h1357_9BDF);
		send_search(32'h0000_0001);
		send_search(32'h8000_0000);
		send_search(32'h7FFF_FFFF);
		send_search(32'hFFFF_FFFF);
		send_search(32'h0000_0000);
		send_search(32'hDEAD_BEEF);
		write_length(tls_pkg::LEN_W'(1));
		send_search(list_mirror[0]);
		send_search(~list_mirror[0]);
		write_length(tls_pkg::LEN_W'(0));
		send_search(list_mirror[0]);
	endtask

	// Fill a long front and scan it to the end; lengths above the depth only on hits
	task automatic test_long_scan();
		for (int unsigned i = 0; i < LONG_FILL; i++)
			send_load(i, $urandom);
		write_length(tls_pkg::LEN_W'(LONG_FILL));
		send_search($urandom);
		send_search(list_mirror[LONG_FILL-1]);
		write_length(tls_pkg::LEN_W'(2047));
		send_search(list_mirror[LONG_FILL-1]);
		write_length(tls_pkg::LEN_W'(1025));
		send_search(list_mirror[LONG_FILL/2]);
		write_length(tls_pkg::LEN_W'(tls_pkg::LIST_DEPTH));
		send_search(list_mirror[LONG_FILL-2]);
	endtask

	// Hold the receiver off while short searches keep coming, so the input stalls
	task automatic test_backpressure();
		write_length(tls_pkg::LEN_W'(16));
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_seq <= hold_seq + 1;
		repeat (20)
			send_search(list_mirror[$urandom_range(3)]);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int unsigned len, input int unsigned window, input int count);
		write_length(tls_pkg::LEN_W'(len));
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (count)
			random_item(window);
	endtask

	// Result acceptor: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted result with the oldest owed one
	always @(posedge clk) begin
		tls_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (search_results_due.size() == 0) begin
				report_mismatch($sformatf("result with none owed: found=%0d position=%0d",
					found, position));
			end else begin
				want = search_results_due.pop_front();
				if (found !== want.found || position !== want.position)
					report_mismatch($sformatf(
						"expected found=%0d position=%0d, got found=%0d position=%0d",
						want.found, want.position, found, position));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_extremes();
		test_long_scan();
		test_backpressure();
		test_random_phase(0, 0, $urandom_range(2, 40), 40, PHASE_ITEMS);
		test_random_phase(79, 0, 1, 1, PHASE_ITEMS);
		test_random_phase(0, 79, 2047, 64, PHASE_ITEMS);
		test_random_phase(7, 7, $urandom_range(100, 700), 128, PHASE_ITEMS);
		wait_idle();
		if (mismatch_count == 0 && search_results_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
